>>> rtl/cutoff_neighbor_pair_finder_defines.svh
// Assertion macros for the checker file.
`ifndef CUTOFF_NEIGHBOR_PAIR_FINDER_DEFINES_SVH
`define CUTOFF_NEIGHBOR_PAIR_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CNPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cnpf check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CNPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cnpf check failed");

`endif

>>> rtl/cnpf_pkg.sv
package cnpf_pkg;

    // Default sizes of the atom table and of the per-atom neighbor limit.
    localparam int MAX_ATOMS_DEF      = 256;
    localparam int NEIGHBOR_LIMIT_DEF = 6;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 10;
    localparam int TYPE_W   = 2;
    localparam int IDX_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Atoms with x above this raw value never pair.
    localparam logic signed [COORD_W-1:0] FAR_LIMIT_RAW = 24'sd2560000;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_LIMIT = 2'd1,
        KIND_FULL  = 2'd2
    } kind_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic store;
        logic scan_start;
        logic issue;
        logic flush;
        logic push_full;
        logic write_ncount;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic adv;
        logic stop;
        logic pipe_busy;
        logic held_valid;
        logic new_far;
    } status_t;

endpackage

>>> rtl/cutoff_neighbor_pair_finder.sv
// Channel   Direction  Beat contents
// s_*       in         tuser: op; tdata: atom_type, pos_x, pos_y, pos_z (bits 0 up)
// m_*       out        tuser: kind; tdata: earlier_index, new_index; tlast: last
// cfg_*     in         cfg_index selects radius_type0..3, cfg_data is the radius
//
// An add of atom n takes the beat, issues the stored atoms through one table read port,
// drains the compare pipe, flushes the held result if there is one and writes the new
// count. A far atom skips the scan and only writes its count, a clear only resets the
// count, and a full-table add pushes a table-full result and waits for the output.
// A waiting result stalls the whole compare pipe; input is taken only when idle.
// Reset clears control and radii; the atom table holds no reset and needs no sweep.
module cutoff_neighbor_pair_finder #(
    parameter int MAX_ATOMS      = cnpf_pkg::MAX_ATOMS_DEF,
    parameter int NEIGHBOR_LIMIT = cnpf_pkg::NEIGHBOR_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [79:0]                       s_tdata,  // atom_type, pos_x, pos_y, pos_z, pad
    input  logic                              s_tuser,  // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // earlier_index, new_index
    output logic [1:0]                        m_tuser,  // kind
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [cnpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cnpf_pkg::RADIUS_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_ATOMS);

    cnpf_pkg::cmd_t    cmd;
    cnpf_pkg::status_t st;
    logic [AW-1:0]     scan_addr, store_addr, n_idx;

    cnpf_ctrl #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .op         (s_tuser),
        .s_tready   (s_tready),
        .st         (st),
        .cmd        (cmd),
        .scan_addr  (scan_addr),
        .store_addr (store_addr),
        .n_idx      (n_idx)
    );

    cnpf_datapath #(
        .MAX_ATOMS      (MAX_ATOMS),
        .NEIGHBOR_LIMIT (NEIGHBOR_LIMIT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .atom_type  (s_tdata[1:0]),
        .pos_x      (s_tdata[25:2]),
        .pos_y      (s_tdata[49:26]),
        .pos_z      (s_tdata[73:50]),
        .cmd        (cmd),
        .scan_addr  (scan_addr),
        .store_addr (store_addr),
        .n_idx      (n_idx),
        .st         (st),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/cnpf_ctrl.sv
module cnpf_ctrl #(
    parameter int MAX_ATOMS = cnpf_pkg::MAX_ATOMS_DEF,
    localparam int AW = $clog2(MAX_ATOMS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 op,
    output logic                 s_tready,
    input  cnpf_pkg::status_t    st,
    output cnpf_pkg::cmd_t       cmd,
    output logic [AW-1:0]        scan_addr,
    output logic [AW-1:0]        store_addr,
    output logic [AW-1:0]        n_idx
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_FLUSH = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_FULL  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW:0]   j_reg, j_next;
    logic [AW-1:0] n_reg, n_next;

    assign scan_addr  = j_reg[AW-1:0];
    assign store_addr = count_reg[AW-1:0];
    assign n_idx      = n_reg;

    // Sequencer for one input beat: store, scan, drain, flush, finish; or clear, or report a full table.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!op)
                    begin
                        count_next = '0;
                    end
                    else if (count_reg == (AW+1)'(MAX_ATOMS))
                    begin
                        state_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.store      = 1'b1;
                        cmd.scan_start = 1'b1;
                        n_next         = count_reg[AW-1:0];
                        count_next     = count_reg + 1'b1;
                        j_next         = '0;
                        state_next     = st.new_far ? ST_FINAL : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (st.stop || (j_reg == {1'b0, n_reg}))
                begin
                    state_next = ST_DRAIN;
                end
                else if (st.adv)
                begin
                    cmd.issue = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!st.pipe_busy)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (st.held_valid)
                begin
                    cmd.flush = 1'b1;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.write_ncount = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_FULL:
            begin
                cmd.push_full = 1'b1;
                if (st.adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
        end
    end

endmodule

>>> rtl/cnpf_datapath.sv
module cnpf_datapath #(
    parameter int MAX_ATOMS      = cnpf_pkg::MAX_ATOMS_DEF,
    parameter int NEIGHBOR_LIMIT = cnpf_pkg::NEIGHBOR_LIMIT_DEF,
    localparam int AW = $clog2(MAX_ATOMS),
    localparam int CW = $clog2(NEIGHBOR_LIMIT + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cnpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cnpf_pkg::RADIUS_W-1:0]       cfg_data,
    input  logic [cnpf_pkg::TYPE_W-1:0]         atom_type,
    input  logic signed [cnpf_pkg::COORD_W-1:0] pos_x,
    input  logic signed [cnpf_pkg::COORD_W-1:0] pos_y,
    input  logic signed [cnpf_pkg::COORD_W-1:0] pos_z,
    input  cnpf_pkg::cmd_t                      cmd,
    input  logic [AW-1:0]                       scan_addr,
    input  logic [AW-1:0]                       store_addr,
    input  logic [AW-1:0]                       n_idx,
    output cnpf_pkg::status_t                   st,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    localparam int DW = cnpf_pkg::COORD_W + 1;
    localparam int RW = cnpf_pkg::RADIUS_W + 1;

    function automatic logic [DW-1:0] abs_diff(
        input logic [cnpf_pkg::COORD_W-1:0] a,
        input logic [cnpf_pkg::COORD_W-1:0] b
    );
        logic signed [DW-1:0] d;
        d = $signed({a[cnpf_pkg::COORD_W-1], a}) - $signed({b[cnpf_pkg::COORD_W-1], b});
        abs_diff = d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    // Radius registers.
    logic [cnpf_pkg::RADIUS_W-1:0] radius_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                radius_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            radius_reg[cfg_index] <= cfg_data;
        end
    end

    // Atom table memories.
    logic [cnpf_pkg::COORD_W-1:0] x_mem [MAX_ATOMS];
    logic [cnpf_pkg::COORD_W-1:0] y_mem [MAX_ATOMS];
    logic [cnpf_pkg::COORD_W-1:0] z_mem [MAX_ATOMS];
    logic [cnpf_pkg::TYPE_W:0]    attr_mem [MAX_ATOMS];
    logic [CW-1:0]                cnt_mem [MAX_ATOMS];

    logic adv;
    logic new_far;

    // New atom held for the scan.
    logic [cnpf_pkg::COORD_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [cnpf_pkg::TYPE_W-1:0]  ntype_reg;
    logic [CW-1:0]                ncnt_reg;

    // Pipeline stage registers.
    logic                         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [AW-1:0]                j1_reg, j2_reg, j3_reg, j4_reg, j5_reg;
    logic [cnpf_pkg::COORD_W-1:0] x1_reg, y1_reg, z1_reg;
    logic [cnpf_pkg::TYPE_W:0]    attr1_reg;
    logic [CW-1:0]                cnt1_reg, cnt2_reg, cnt3_reg, cnt4_reg, cnt5_reg;
    logic                         abs2_reg, abs3_reg, abs4_reg, abs5_reg;
    logic [DW-1:0]                dx2_reg, dy2_reg, dz2_reg;
    logic [RW-1:0]                rs2_reg;
    logic [2*DW-1:0]              sx3_reg, sy3_reg, sz3_reg;
    logic [2*RW-1:0]              rsq3_reg;
    logic [2*DW:0]                d2_4_reg;
    logic [2*RW+4:0]              rhs4_reg;

    // Result holding and output registers.
    logic                 stop_reg;
    logic                 held_valid_reg;
    cnpf_pkg::kind_t      held_kind_reg;
    logic [7:0]           held_e_reg;
    logic                 out_valid_reg;
    cnpf_pkg::kind_t      out_kind_reg;
    logic [7:0]           out_e_reg, out_n_reg;
    logic                 out_last_reg;

    logic          bond5, limit5, ev5;
    logic [2*DW+4:0] lhs5;

    assign adv     = !out_valid_reg || m_tready;
    assign new_far = pos_x > cnpf_pkg::FAR_LIMIT_RAW;

    assign st.adv        = adv;
    assign st.stop       = stop_reg;
    assign st.pipe_busy  = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign st.held_valid = held_valid_reg;
    assign st.new_far    = new_far;

    // Table writes on store, registered reads while the pipeline moves.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            x_mem[store_addr]    <= pos_x;
            y_mem[store_addr]    <= pos_y;
            z_mem[store_addr]    <= pos_z;
            attr_mem[store_addr] <= {new_far, atom_type};
            nx_reg    <= pos_x;
            ny_reg    <= pos_y;
            nz_reg    <= pos_z;
            ntype_reg <= atom_type;
        end
        if (adv)
        begin
            x1_reg    <= x_mem[scan_addr];
            y1_reg    <= y_mem[scan_addr];
            z1_reg    <= z_mem[scan_addr];
            attr1_reg <= attr_mem[scan_addr];
        end
    end

    // Neighbor counts: bump the stored atom on a bond, write the new atom at the end.
    always_ff @(posedge clk)
    begin
        if (ev5 && !limit5)
        begin
            cnt_mem[j5_reg] <= cnt5_reg + 1'b1;
        end
        else if (cmd.write_ncount)
        begin
            cnt_mem[n_idx] <= ncnt_reg;
        end
        if (adv)
        begin
            cnt1_reg <= cnt_mem[scan_addr];
        end
    end

    // Distance and radius arithmetic stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j1_reg   <= scan_addr;
            j2_reg   <= j1_reg;
            dx2_reg  <= abs_diff(x1_reg, nx_reg);
            dy2_reg  <= abs_diff(y1_reg, ny_reg);
            dz2_reg  <= abs_diff(z1_reg, nz_reg);
            rs2_reg  <= {1'b0, radius_reg[ntype_reg]}
                      + {1'b0, radius_reg[attr1_reg[cnpf_pkg::TYPE_W-1:0]]};
            abs2_reg <= attr1_reg[cnpf_pkg::TYPE_W];
            cnt2_reg <= cnt1_reg;
            j3_reg   <= j2_reg;
            sx3_reg  <= dx2_reg * dx2_reg;
            sy3_reg  <= dy2_reg * dy2_reg;
            sz3_reg  <= dz2_reg * dz2_reg;
            rsq3_reg <= rs2_reg * rs2_reg;
            abs3_reg <= abs2_reg;
            cnt3_reg <= cnt2_reg;
            j4_reg   <= j3_reg;
            d2_4_reg <= (2*DW+1)'(sx3_reg) + (2*DW+1)'(sy3_reg) + (2*DW+1)'(sz3_reg);
            rhs4_reg <= (2*RW+5)'(rsq3_reg) * (2*RW+5)'(25);
            abs4_reg <= abs3_reg;
            cnt4_reg <= cnt3_reg;
            j5_reg   <= j4_reg;
            abs5_reg <= abs4_reg;
            cnt5_reg <= cnt4_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Last stage: 16*d2 against 25*(ra+rb)^2, then the limit check.
    logic [2*DW+4:0] d2_5_reg;
    logic [2*RW+4:0] rhs5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_5_reg <= {d2_4_reg, 4'b0000};
            rhs5_reg <= rhs4_reg;
        end
    end

    assign lhs5   = d2_5_reg;
    assign bond5  = lhs5 <= (2*DW+5)'(rhs5_reg);
    assign limit5 = (cnt5_reg >= CW'(NEIGHBOR_LIMIT)) || (ncnt_reg >= CW'(NEIGHBOR_LIMIT));
    assign ev5    = adv && v5_reg && !stop_reg && !abs5_reg && bond5;

    // Result hold, so the final result of an atom can carry last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            ncnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                stop_reg       <= 1'b0;
                held_valid_reg <= 1'b0;
                ncnt_reg       <= '0;
            end
            if (ev5)
            begin
                held_valid_reg <= 1'b1;
                if (held_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                if (limit5)
                begin
                    stop_reg <= 1'b1;
                end
                else
                begin
                    ncnt_reg <= ncnt_reg + 1'b1;
                end
            end
            if (cmd.flush && adv)
            begin
                held_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            if (cmd.push_full && adv)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (ev5)
        begin
            held_kind_reg <= limit5 ? cnpf_pkg::KIND_LIMIT : cnpf_pkg::KIND_PAIR;
            held_e_reg    <= 8'(j5_reg);
            if (held_valid_reg)
            begin
                out_kind_reg <= held_kind_reg;
                out_e_reg    <= held_e_reg;
                out_n_reg    <= 8'(n_idx);
                out_last_reg <= 1'b0;
            end
        end
        if (cmd.flush && adv)
        begin
            out_kind_reg <= held_kind_reg;
            out_e_reg    <= held_e_reg;
            out_n_reg    <= 8'(n_idx);
            out_last_reg <= 1'b1;
        end
        if (cmd.push_full && adv)
        begin
            out_kind_reg <= cnpf_pkg::KIND_FULL;
            out_e_reg    <= '0;
            out_n_reg    <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_n_reg, out_e_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/cnpf_checker.sv
`include "cutoff_neighbor_pair_finder_defines.svh"

module cnpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result beat holds.
    `CNPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A table-full result carries zero indices and ends its item.
    `CNPF_ASSERT_NOW(a_full_form, m_tvalid && (m_tuser == 2'(cnpf_pkg::KIND_FULL)), (m_tdata == 16'd0) && m_tlast)

    // A neighbor-limit result always ends its item.
    `CNPF_ASSERT_NOW(a_limit_last, m_tvalid && (m_tuser == 2'(cnpf_pkg::KIND_LIMIT)), m_tlast)

    // No new input is taken while an item still has results to come.
    `CNPF_ASSERT_NOW(a_no_overlap, m_tvalid && !m_tlast, !s_tready)

endmodule

bind cutoff_neighbor_pair_finder cnpf_checker u_cnpf_checker (.*);

>>> tb/sv/cnpf_checker.sv
`timescale 1ns / 100ps

module cnpf_tb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,  // atom_type, pos_x, pos_y, pos_z, pad
    input  logic        s_tuser,  // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,  // earlier_index, new_index
    input  logic [1:0]  m_tuser,  // kind
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int TABLE_DEPTH = cnpf_pkg::MAX_ATOMS_DEF;
    localparam int NBR_LIMIT   = cnpf_pkg::NEIGHBOR_LIMIT_DEF;

    typedef struct packed {
        cnpf_pkg::kind_t kind;
        logic [7:0]      earlier;
        logic [7:0]      newer;
        logic            last;
    } pair_result_t;

    pair_result_t    result_queue[$];
    logic [9:0]      radius[4];
    logic signed [23:0] atom_x[TABLE_DEPTH];
    logic signed [23:0] atom_y[TABLE_DEPTH];
    logic signed [23:0] atom_z[TABLE_DEPTH];
    logic [1:0]      atom_kind[TABLE_DEPTH];
    logic            atom_far[TABLE_DEPTH];
    int              nbr_count[TABLE_DEPTH];
    int              stored_atoms;

    assign pending = result_queue.size();

    // Squared distance between the new atom and a stored one, exact in 64 bits.
    function automatic longint unsigned dist_sq(logic signed [23:0] ax, logic signed [23:0] ay,
                                                logic signed [23:0] az, int j);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(ax) - longint'(atom_x[j]);
        dy = longint'(ay) - longint'(atom_y[j]);
        dz = longint'(az) - longint'(atom_z[j]);
        return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    // Work out the results of one accepted input beat.
    task automatic predict_pairs(logic op, logic [79:0] d);
        logic [1:0] t;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        int n;
        int found;
        longint unsigned rs;
        pair_result_t r;
        found = 0;
        if (!op)
        begin
            stored_atoms = 0;
            return;
        end
        if (stored_atoms >= TABLE_DEPTH)
        begin
            r = '{cnpf_pkg::KIND_FULL, 8'd0, 8'd0, 1'b1};
            result_queue.push_back(r);
            return;
        end
        t  = d[1:0];
        px = d[25:2];
        py = d[49:26];
        pz = d[73:50];
        n  = stored_atoms;
        atom_x[n] = px;
        atom_y[n] = py;
        atom_z[n] = pz;
        atom_kind[n] = t;
        atom_far[n] = (px > cnpf_pkg::FAR_LIMIT_RAW);
        nbr_count[n] = 0;
        stored_atoms = n + 1;
        if (atom_far[n])
            return;
        for (int j = 0; j < n; j++)
        begin
            if (atom_far[j])
                continue;
            rs = longint'(radius[t]) + longint'(radius[atom_kind[j]]);
            if (16 * dist_sq(px, py, pz, j) > 25 * rs * rs)
                continue;
            if (nbr_count[j] >= NBR_LIMIT || nbr_count[n] >= NBR_LIMIT)
            begin
                r = '{cnpf_pkg::KIND_LIMIT, 8'(j), 8'(n), 1'b1};
                result_queue.push_back(r);
                return;
            end
            nbr_count[j]++;
            nbr_count[n]++;
            r = '{cnpf_pkg::KIND_PAIR, 8'(j), 8'(n), 1'b0};
            result_queue.push_back(r);
            found++;
        end
        if (found > 0)
            result_queue[$].last = 1'b1;
    endtask

    // Watch the configuration port and both streams.
    always @(posedge clk or negedge rst_n)
    begin
        pair_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                radius[i] = '0;
            stored_atoms = 0;
            fail_count = 0;
            result_queue.delete();
        end
        else
        begin
            if (cfg_we)
                radius[cfg_index] = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("unexpected result beat kind=%0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (m_tuser != want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] != want.earlier)
                    begin
                        $error("earlier_index: expected %0d, actual %0d",
                               want.earlier, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[15:8] != want.newer)
                    begin
                        $error("new_index: expected %0d, actual %0d",
                               want.newer, m_tdata[15:8]);
                        fail_count++;
                    end
                    if (m_tlast != want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_pairs(s_tuser, s_tdata);
        end
    end

endmodule

>>> tb/sv/tb_cutoff_neighbor_pair_finder.sv
`timescale 1ns / 100ps

module tb_cutoff_neighbor_pair_finder;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;
    localparam int   RANDOM_BEATS = 48;
    localparam int   FRAME_BEATS  = 12;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;  // atom_type, pos_x, pos_y, pos_z, pad
    logic        s_tuser;  // op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;  // earlier_index, new_index
    logic [1:0]  m_tuser;  // kind
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;
    int          fail_count;
    int          pending;
    bit          calm;

    cutoff_neighbor_pair_finder i_dut (.*);

    cnpf_tb_checker i_checker (.*);

    // Clock with a 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver side: random stalls except during the calm stretch.
    always @(negedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // Hand one beat to the block and wait for it to be taken.
    task automatic send_beat(logic op, logic [1:0] t, logic [23:0] x, logic [23:0] y,
                             logic [23:0] z);
        while (!calm && $urandom_range(99) < 31)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {6'd0, z, y, x, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_radius(logic [1:0] idx, logic [9:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Drain every expected result, then let the pipe settle.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (400)
            @(negedge clk);
    endtask

    // Coordinate near a cluster center, kept within 24 bits.
    function automatic logic [23:0] near(int center, int spread);
        return 24'(center + $signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic set_radii(int lo, int hi);
        for (int i = 0; i < 4; i++)
            write_radius(2'(i), 10'($urandom_range(hi, lo)));
    endtask

    initial
    begin
        int mode;
        int c;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: radii at zero, coincident atoms still bond at zero distance.
        send_beat(OP_ADD, 2'd0, 24'd0, 24'd0, 24'd0);
        send_beat(OP_ADD, 2'd1, 24'd0, 24'd0, 24'd0);
        send_beat(OP_ADD, 2'd2, 24'd1, 24'd0, 24'd0);
        drain();
        write_radius(2'd0, 10'd1023);
        write_radius(2'd1, 10'd1023);
        write_radius(2'd2, 10'd0);
        write_radius(2'd3, 10'd512);
        send_beat(OP_CLEAR, 2'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        // Extreme corners and a far atom.
        send_beat(OP_ADD, 2'd0, 24'h800000, 24'h800000, 24'h800000);
        send_beat(OP_ADD, 2'd3, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_beat(OP_ADD, 2'd1, 24'd2560001, 24'd0, 24'd0);
        send_beat(OP_ADD, 2'd1, 24'd2560000, 24'd0, 24'd0);
        // Neighbor limit: a tight cluster of eight.
        for (int i = 0; i < 8; i++)
            send_beat(OP_ADD, 2'd0, 24'd100, 24'(i), 24'd0);
        drain();

        // Table full: fill with far atoms, then add two more.
        send_beat(OP_CLEAR, 2'd0, '0, '0, '0);
        calm = 1'b1;
        for (int i = 0; i < 256; i++)
            send_beat(OP_ADD, 2'(i), 24'd3000000, 24'(i), 24'd0);
        calm = 1'b0;
        send_beat(OP_ADD, 2'd0, 24'd0, 24'd0, 24'd0);
        send_beat(OP_ADD, 2'd3, 24'd5, 24'd5, 24'd5);
        drain();

        // Random: clustered frames with occasional noise and clears.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % FRAME_BEATS == 0)
            begin
                drain();
                mode = i / FRAME_BEATS;
                if (mode == 0)
                    set_radii(0, 1023);
                else if (mode == 1)
                    set_radii(0, 50);
                else if (mode == 2)
                    set_radii(1023, 1023);
                else
                    set_radii(200, 600);
                send_beat(OP_CLEAR, 2'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
            end
            calm = (i >= 26 && i < 34);
            c = $urandom_range(99);
            if (c < 4)
                send_beat(OP_CLEAR, 2'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
            else if (c < 14)
                send_beat(OP_ADD, 2'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
            else
                send_beat(OP_ADD, 2'($urandom), near(-4000, 1500), near(3000, 1500),
                          near(0, 1500));
            if (i == 44)
            begin
                // Hold the sender until the block has caught up.
                while (pending != 0)
                    @(negedge clk);
            end
        end
        calm = 1'b0;
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit.
    initial
    begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule
